@@ src/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// Software timer table package
// Shared command types, status and action codes for the timer table.
// ----------------------------------------------------------------------------
package stt_pkg;

	// Input action codes.
	localparam logic [1:0] ACT_REGISTER = 2'd0;
	localparam logic [1:0] ACT_CANCEL   = 2'd1;
	localparam logic [1:0] ACT_TICK     = 2'd2;
	localparam logic [1:0] ACT_SET_TIME = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_PARAM     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_EXPIRED   = 2'd3;

	// Depth of the command queue between front and back.
	localparam int QDEPTH = 2;

	// Classified command kinds produced by the front end.
	typedef enum logic [2:0] {
		CMD_PARAM_ERR,
		CMD_REGISTER,
		CMD_CANCEL,
		CMD_TICK,
		CMD_IDLE_TICK,
		CMD_SET_TIME
	} cmd_kind_t;

	// One queued command word.
	typedef struct packed {
		cmd_kind_t   kind;
		logic [3:0]  handle;
		logic [31:0] value;
	} cmd_t;

	// Back end sequencer states.
	typedef enum logic [0:0] {
		BK_IDLE,
		BK_SCAN
	} back_state_t;

endpackage

@@ src/stt_front.sv @@
// ----------------------------------------------------------------------------
// Software timer table front end
// Accepts input words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module stt_front #(
	parameter int TIMER_SLOTS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       action,
	input  logic [3:0]       handle,
	input  logic [31:0]      ticks,
	input  logic [31:0]      new_time,
	input  logic             running_enable,
	output stt_pkg::cmd_t    cmd,
	output logic             cmd_valid,
	input  logic             cmd_pop
);
	import stt_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	cmd_t          queue_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          handle_bad;
	cmd_t          cmd_new;

	// The queue accepts a word whenever it has room.
	assign busy      = (count_q == CW'(QDEPTH));
	assign push      = start && !busy;
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];

	// Classify the incoming word; a handle beyond the table is a parameter error.
	assign handle_bad = ({28'd0, handle} >= 32'(TIMER_SLOTS));

	always_comb begin
		cmd_new.handle = handle;
		cmd_new.value  = ticks;
		unique case (action)
			ACT_REGISTER: begin
				cmd_new.kind = (ticks == '0 || handle_bad) ? CMD_PARAM_ERR : CMD_REGISTER;
			end
			ACT_CANCEL: begin
				cmd_new.kind = handle_bad ? CMD_PARAM_ERR : CMD_CANCEL;
			end
			ACT_TICK: begin
				cmd_new.kind = running_enable ? CMD_TICK : CMD_IDLE_TICK;
			end
			default: begin
				cmd_new.kind  = CMD_SET_TIME;
				cmd_new.value = new_time;
			end
		endcase
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_new;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/stt_back.sv @@
// ----------------------------------------------------------------------------
// Software timer table back end
// Holds the timer slots and carries out queued commands, one command a cycle while no expiry scan is running.
// ----------------------------------------------------------------------------
module stt_back #(
	parameter int TIMER_SLOTS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  stt_pkg::cmd_t    cmd,
	input  logic             cmd_valid,
	output logic             cmd_pop,
	output logic             strobe,
	output logic [1:0]       status,
	output logic [3:0]       expired_handle,
	output logic             last,
	output logic [31:0]      time_now
);
	import stt_pkg::*;

	localparam int SW = $clog2(TIMER_SLOTS);
	localparam int EW = SW + 1;

	// Slot state and tick count.
	logic [TIMER_SLOTS-1:0] armed_q, armed_d;
	logic [SW-1:0]          rank_q [TIMER_SLOTS];
	logic [SW-1:0]          rank_d [TIMER_SLOTS];
	logic [31:0]            remain_q [TIMER_SLOTS];
	logic [31:0]            remain_d [TIMER_SLOTS];
	logic [31:0]            time_q, time_d;

	// Expiry scan state.
	back_state_t            state_q, state_d;
	logic [TIMER_SLOTS-1:0] pending_q, pending_d;
	logic [TIMER_SLOTS-1:0] expired_q, expired_d;
	logic [EW-1:0]          exp_total_q, exp_total_d;
	logic [EW-1:0]          emitted_q, emitted_d;
	logic [SW-1:0]          scan_q, scan_d;
	logic [SW-1:0]          next_rank_q, next_rank_d;

	// Result registers.
	logic                   strobe_q, strobe_d;
	logic [1:0]             status_q, status_d;
	logic [3:0]             handle_q, handle_d;
	logic                   last_q, last_d;

	// Per-slot helpers.
	logic [SW-1:0]          sel;
	logic                   sel_armed;
	logic [SW-1:0]          sel_rank;
	logic [TIMER_SLOTS-1:0] expv;
	logic [EW-1:0]          exp_count;
	logic                   hit_any;
	logic [SW-1:0]          hit_idx;

	assign sel       = SW'(cmd.handle);
	assign sel_armed = armed_q[sel];
	assign sel_rank  = rank_q[sel];

	// Slots that reach zero on this tick.
	always_comb begin
		for (int i = 0; i < TIMER_SLOTS; i++) begin
			expv[i] = armed_q[i] && (remain_q[i] == 32'd1);
		end
		exp_count = EW'($countones(expv));
	end

	// Find the slot that holds the rank under scan.
	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < TIMER_SLOTS; i++) begin
			if (pending_q[i] && rank_q[i] == scan_q) begin
				hit_any = 1'b1;
				hit_idx = hit_idx | SW'(i);
			end
		end
	end

	// Command execution and expiry sequencing.
	always_comb begin
		state_d     = state_q;
		armed_d     = armed_q;
		rank_d      = rank_q;
		remain_d    = remain_q;
		time_d      = time_q;
		pending_d   = pending_q;
		expired_d   = expired_q;
		exp_total_d = exp_total_q;
		emitted_d   = emitted_q;
		scan_d      = scan_q;
		next_rank_d = next_rank_q;
		cmd_pop     = 1'b0;
		strobe_d    = 1'b0;
		status_d    = ST_OK;
		handle_d    = '0;
		last_d      = 1'b1;

		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop  = 1'b1;
					strobe_d = 1'b1;
					unique case (cmd.kind)
						CMD_PARAM_ERR: begin
							status_d = ST_PARAM;
						end
						CMD_REGISTER: begin
							// Others age by one, except those older than a re-armed slot.
							for (int i = 0; i < TIMER_SLOTS; i++) begin
								if (armed_q[i] && SW'(i) != sel &&
								    !(sel_armed && rank_q[i] > sel_rank)) begin
									rank_d[i] = rank_q[i] + 1'b1;
								end
							end
							armed_d[sel]  = 1'b1;
							rank_d[sel]   = '0;
							remain_d[sel] = cmd.value;
						end
						CMD_CANCEL: begin
							if (!sel_armed) begin
								status_d = ST_NOT_FOUND;
							end else begin
								for (int i = 0; i < TIMER_SLOTS; i++) begin
									if (armed_q[i] && SW'(i) != sel && rank_q[i] > sel_rank) begin
										rank_d[i] = rank_q[i] - 1'b1;
									end
								end
								armed_d[sel]  = 1'b0;
								rank_d[sel]   = '0;
								remain_d[sel] = '0;
							end
						end
						CMD_TICK: begin
							time_d = time_q + 32'd1;
							for (int i = 0; i < TIMER_SLOTS; i++) begin
								if (armed_q[i]) begin
									remain_d[i] = remain_q[i] - 32'd1;
								end
							end
							armed_d = armed_q & ~expv;
							if (exp_count != '0) begin
								strobe_d    = 1'b0;
								pending_d   = armed_q;
								expired_d   = expv;
								exp_total_d = exp_count;
								emitted_d   = '0;
								scan_d      = '0;
								next_rank_d = '0;
								state_d     = BK_SCAN;
							end
						end
						CMD_IDLE_TICK: begin
							status_d = ST_OK;
						end
						CMD_SET_TIME: begin
							time_d = cmd.value;
						end
						default: begin
							status_d = ST_OK;
						end
					endcase
				end
			end
			BK_SCAN: begin
				// Walk ranks newest first: report expiries, renumber survivors.
				if (hit_any) begin
					pending_d[hit_idx] = 1'b0;
					if (expired_q[hit_idx]) begin
						strobe_d        = 1'b1;
						status_d        = ST_EXPIRED;
						handle_d        = 4'(hit_idx);
						last_d          = (EW'(emitted_q + 1'b1) == exp_total_q);
						emitted_d       = emitted_q + 1'b1;
						rank_d[hit_idx] = '0;
					end else begin
						rank_d[hit_idx] = next_rank_q;
						next_rank_d     = next_rank_q + 1'b1;
					end
				end
				if (scan_q == SW'(TIMER_SLOTS - 1)) begin
					state_d = BK_IDLE;
				end else begin
					scan_d = scan_q + 1'b1;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			armed_q  <= '0;
			time_q   <= '0;
			strobe_q <= 1'b0;
			for (int i = 0; i < TIMER_SLOTS; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			state_q  <= state_d;
			armed_q  <= armed_d;
			time_q   <= time_d;
			strobe_q <= strobe_d;
			rank_q   <= rank_d;
		end
	end

	// Payload and scan bookkeeping.
	always_ff @(posedge clk) begin
		remain_q    <= remain_d;
		pending_q   <= pending_d;
		expired_q   <= expired_d;
		exp_total_q <= exp_total_d;
		emitted_q   <= emitted_d;
		scan_q      <= scan_d;
		next_rank_q <= next_rank_d;
		status_q    <= status_d;
		handle_q    <= handle_d;
		last_q      <= last_d;
	end

	assign strobe         = strobe_q;
	assign status         = status_q;
	assign expired_handle = handle_q;
	assign last           = last_q;
	assign time_now       = time_q;

endmodule

@@ src/software_timer_table.sv @@
// ----------------------------------------------------------------------------
// Software timer table
// Table of one-shot countdown timers addressed by handle, with a register port.
// ----------------------------------------------------------------------------
// A result is strobed from the back-end result registers after its input word
// has passed the command queue. A tick with expiries starts a rank scan over all
// slots that reports the expired timers in turn; a two-word queue lets input go
// on meanwhile. Reset clears all timers, the tick count and running_enable;
// results cannot stall.
// ----------------------------------------------------------------------------
module software_timer_table #(
	parameter int TIMER_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [3:0]  handle,
	input  logic [31:0] ticks,
	input  logic [31:0] new_time,
	output logic        strobe,
	output logic [1:0]  status,
	output logic [3:0]  expired_handle,
	output logic        last,
	output logic [31:0] time_now,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import stt_pkg::*;

	logic running_q;
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;

	// Register port: running_enable at address zero.
	assign pready = 1'b1;
	assign prdata = (paddr == 1'b0) ? {31'd0, running_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr == 1'b0) begin
			running_q <= pwdata[0];
		end
	end

	stt_front #(
		.TIMER_SLOTS(TIMER_SLOTS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.handle         (handle),
		.ticks          (ticks),
		.new_time       (new_time),
		.running_enable (running_q),
		.cmd            (cmd),
		.cmd_valid      (cmd_valid),
		.cmd_pop        (cmd_pop)
	);

	stt_back #(
		.TIMER_SLOTS(TIMER_SLOTS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cmd_valid      (cmd_valid),
		.cmd_pop        (cmd_pop),
		.strobe         (strobe),
		.status         (status),
		.expired_handle (expired_handle),
		.last           (last),
		.time_now       (time_now)
	);

endmodule
